// File: rtl/cte_pkg.sv
`default_nettype none
package cte_pkg;

   localparam int MAX_FACE_DIM_DEF = 4096;
   localparam int MAX_SRC_DIM_DEF  = 8192;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int POS_W        = 12;
   localparam int DIM_W        = 13;
   localparam int SRC_W        = 14;
   localparam int TAN_W        = 18;
   localparam int PROD_W       = DIM_W + TAN_W;
   localparam int VEC_W        = 32;
   localparam int SQ_W         = 2 * VEC_W;
   localparam int RAD_W        = VEC_W;
   localparam int ANG_W        = 35;
   localparam int CORDIC_XW    = 44;
   localparam int CORDIC_SH    = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 18;

   localparam logic [2:0] FACE_FRONT  = 3'd0;
   localparam logic [2:0] FACE_RIGHT  = 3'd1;
   localparam logic [2:0] FACE_BACK   = 3'd2;
   localparam logic [2:0] FACE_LEFT   = 3'd3;
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_FACE_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_HEIGHT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUIRECT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EQUIRECT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_FOV_TAN    = 3'd4;

   localparam logic signed [ANG_W-1:0] HALF_TURN = 35'sh0_8000_0000;

   typedef struct packed {
      logic [2:0]       face_select;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } req_beat_type;

   typedef struct packed {
      logic [12:0] src_x;
      logic [12:0] src_y;
      logic [16:0] longitude_frac;
      logic [16:0] latitude_frac;
   } rsp_beat_type;

   // atan(2^-k) in 2^-32 turn
   function automatic logic [31:0] atan_step(input int k);
      logic [31:0] r;
      unique case (k)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/cte_div.sv
`default_nettype none
module cte_div import cte_pkg::*; #(
   parameter int NUM_W = PROD_W,
   parameter int DEN_W = DIM_W,
   parameter int TAG_W = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire logic [1:0][NUM_W-1:0]  in_num,
   input  wire logic [1:0][DEN_W-1:0]  in_den,
   input  wire logic [TAG_W-1:0]       in_tag,
   output logic                        out_valid,
   output logic [1:0][NUM_W-1:0]       out_quo,
   output logic [TAG_W-1:0]            out_tag
);

   // restoring divide, one quotient bit per stage
   logic [NUM_W-1:0]            valid_ff;
   logic [1:0][DEN_W-1:0]       rem_ff [NUM_W];
   logic [1:0][NUM_W-1:0]       acc_ff [NUM_W];
   logic [TAG_W-1:0]            tag_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic                  prev_valid;
      logic [1:0][DEN_W-1:0] prev_rem;
      logic [1:0][NUM_W-1:0] prev_acc;
      logic [TAG_W-1:0]      prev_tag;
      logic [1:0][DEN_W:0]   trial;
      logic [1:0][DEN_W-1:0] rem_in;
      logic [1:0][NUM_W-1:0] acc_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_acc   = in_num;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_acc   = acc_ff[s-1];
         assign prev_tag   = tag_ff[s-1];
      end

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {prev_rem[l], prev_acc[l][NUM_W-1]};
            if (trial[l] >= {1'b0, in_den[l]}) begin
               rem_in[l] = DEN_W'(trial[l] - {1'b0, in_den[l]});
               acc_in[l] = {prev_acc[l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][DEN_W-1:0];
               acc_in[l] = {prev_acc[l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            acc_ff[s] <= acc_in;
            tag_ff[s] <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = acc_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule
`default_nettype wire

// File: rtl/cte_sqrt.sv
`default_nettype none
module cte_sqrt import cte_pkg::*; #(
   parameter int ROOT_W = RAD_W,
   parameter int TAG_W  = 3 * VEC_W
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [2*ROOT_W-1:0]   in_val,
   input  wire logic [TAG_W-1:0]      in_tag,
   output logic                       out_valid,
   output logic [ROOT_W-1:0]          out_root,
   output logic [TAG_W-1:0]           out_tag
);

   localparam int IN_W  = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   // digit-by-digit floor root, one root bit per stage
   logic [ROOT_W-1:0] valid_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [IN_W-1:0]   num_ff  [ROOT_W];
   logic [TAG_W-1:0]  tag_ff  [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic              prev_valid;
      logic [REM_W-1:0]  prev_rem;
      logic [ROOT_W-1:0] prev_root;
      logic [IN_W-1:0]   prev_num;
      logic [TAG_W-1:0]  prev_tag;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = '0;
         assign prev_root  = '0;
         assign prev_num   = in_val;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_root  = root_ff[s-1];
         assign prev_num   = num_ff[s-1];
         assign prev_tag   = tag_ff[s-1];
      end

      always_comb begin
         rem_sh = {prev_rem[ROOT_W-1:0], prev_num[IN_W-1:IN_W-2]};
         trial  = {prev_root, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {prev_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {prev_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            num_ff[s]  <= {prev_num[IN_W-3:0], 2'b00};
            tag_ff[s]  <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule
`default_nettype wire

// File: rtl/cte_cordic.sv
`default_nettype none
module cte_cordic import cte_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic signed [VEC_W:0]    in_y [2],
   input  wire logic signed [VEC_W:0]    in_x [2],
   output logic                          out_valid,
   output logic signed [ANG_W-1:0]       out_ang [2]
);

   localparam int XW = CORDIC_XW;

   // two vectoring lanes; stage 0 folds the left half-plane and scales
   logic [STEPS:0]           valid_ff;
   logic signed [XW-1:0]     x_ff   [STEPS+1][2];
   logic signed [XW-1:0]     y_ff   [STEPS+1][2];
   logic signed [ANG_W-1:0]  ang_ff [STEPS+1][2];
   logic [1:0]               axis_ff [STEPS+1];
   logic [1:0]               back_ff [STEPS+1];

   logic signed [XW-1:0]     x_pre [2];
   logic signed [XW-1:0]     y_pre [2];
   logic signed [ANG_W-1:0]  ang_pre [2];
   logic [1:0]               axis_pre;
   logic [1:0]               back_pre;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         axis_pre[l] = (in_y[l] == '0);
         back_pre[l] = in_x[l][VEC_W];
         if (in_x[l][VEC_W]) begin
            x_pre[l]   = (-XW'(in_x[l])) <<< CORDIC_SH;
            y_pre[l]   = (-XW'(in_y[l])) <<< CORDIC_SH;
            ang_pre[l] = (in_y[l] > 0) ? HALF_TURN : -HALF_TURN;
         end else begin
            x_pre[l]   = XW'(in_x[l]) <<< CORDIC_SH;
            y_pre[l]   = XW'(in_y[l]) <<< CORDIC_SH;
            ang_pre[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x_pre;
         y_ff[0]    <= y_pre;
         ang_ff[0]  <= ang_pre;
         axis_ff[0] <= axis_pre;
         back_ff[0] <= back_pre;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic signed [ANG_W-1:0] ATAN_K = ANG_W'(atan_step(k));
      logic signed [XW-1:0]    x_in [2];
      logic signed [XW-1:0]    y_in [2];
      logic signed [ANG_W-1:0] ang_in [2];

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (y_ff[k][l] > 0) begin
               x_in[l]   = x_ff[k][l] + (y_ff[k][l] >>> k);
               y_in[l]   = y_ff[k][l] - (x_ff[k][l] >>> k);
               ang_in[l] = ang_ff[k][l] + ATAN_K;
            end else begin
               x_in[l]   = x_ff[k][l] - (y_ff[k][l] >>> k);
               y_in[l]   = y_ff[k][l] + (x_ff[k][l] >>> k);
               ang_in[l] = ang_ff[k][l] - ATAN_K;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k+1]    <= x_in;
            y_ff[k+1]    <= y_in;
            ang_ff[k+1]  <= ang_in;
            axis_ff[k+1] <= axis_ff[k];
            back_ff[k+1] <= back_ff[k];
         end
      end
   end

   // on the x axis the angle is exact
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (axis_ff[STEPS][l]) begin
            out_ang[l] = back_ff[STEPS][l] ? HALF_TURN : '0;
         end else begin
            out_ang[l] = ang_ff[STEPS][l];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];

endmodule
`default_nettype wire

// File: rtl/cubemap_to_equirect_address.sv
`default_nettype none
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_beat_type (face_select, col, row)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_beat_type (src_x, src_y, lon/lat frac)
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_stall is low. The pipeline runs through the
// 31-stage plane divider, the 32-stage square root and the CORDIC stages.
// Synchronous reset clears all valids and loads the register defaults.
// A held result parks in a skid register; req_stall is that register's full flag.
module cubemap_to_equirect_address import cte_pkg::*; #(
   parameter int MAX_FACE_DIM = MAX_FACE_DIM_DEF,
   parameter int MAX_SRC_DIM  = MAX_SRC_DIM_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_beat_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_beat_type                rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int U_W = FRAC_BITS + 1;
   localparam int P_W = U_W + SRC_W;

   // ---------------- registers ----------------
   logic [DIM_W-1:0] face_width_ff, face_height_ff;
   logic [SRC_W-1:0] equirect_width_ff, equirect_height_ff;
   logic [TAN_W-1:0] half_fov_tangent_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_width_ff       <= 13'd512;
         face_height_ff      <= 13'd512;
         equirect_width_ff   <= 14'd1920;
         equirect_height_ff  <= 14'd960;
         half_fov_tangent_ff <= 18'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FACE_WIDTH:      face_width_ff       <= csr_wdata[DIM_W-1:0];
            CSR_FACE_HEIGHT:     face_height_ff      <= csr_wdata[DIM_W-1:0];
            CSR_EQUIRECT_WIDTH:  equirect_width_ff   <= csr_wdata[SRC_W-1:0];
            CSR_EQUIRECT_HEIGHT: equirect_height_ff  <= csr_wdata[SRC_W-1:0];
            CSR_HALF_FOV_TAN:    half_fov_tangent_ff <= csr_wdata[TAN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] fw, fh;
   logic [SRC_W-1:0] sw, sh;

   always_comb begin
      if (face_width_ff == '0) fw = DIM_W'(1);
      else if (int'(face_width_ff) > MAX_FACE_DIM) fw = DIM_W'(MAX_FACE_DIM);
      else fw = face_width_ff;
      if (face_height_ff == '0) fh = DIM_W'(1);
      else if (int'(face_height_ff) > MAX_FACE_DIM) fh = DIM_W'(MAX_FACE_DIM);
      else fh = face_height_ff;
      if (equirect_width_ff == '0) sw = SRC_W'(1);
      else if (int'(equirect_width_ff) > MAX_SRC_DIM) sw = SRC_W'(MAX_SRC_DIM);
      else sw = equirect_width_ff;
      if (equirect_height_ff == '0) sh = SRC_W'(1);
      else if (int'(equirect_height_ff) > MAX_SRC_DIM) sh = SRC_W'(MAX_SRC_DIM);
      else sh = equirect_height_ff;
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic skid_valid_ff;
   logic rsp_valid_ff;
   rsp_beat_type skid_data_ff, rsp_data_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- stage A: offsets from face center ----------------
   logic              a_valid_ff;
   logic [2:0]        a_face_ff;
   logic              a_negx_ff, a_negy_ff;
   logic [DIM_W-1:0]  a_magx_ff, a_magy_ff;
   logic signed [DIM_W+1:0] offx, offy;

   always_comb begin
      offx = $signed({2'b00, req_data.col, 1'b0}) - $signed({2'b00, fw});
      offy = $signed({2'b00, req_data.row, 1'b0}) - $signed({2'b00, fh});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_face_ff <= req_data.face_select;
         a_negx_ff <= offx[DIM_W+1];
         a_negy_ff <= offy[DIM_W+1];
         a_magx_ff <= offx[DIM_W+1] ? DIM_W'(-offx) : DIM_W'(offx);
         a_magy_ff <= offy[DIM_W+1] ? DIM_W'(-offy) : DIM_W'(offy);
      end
   end

   // ---------------- stage B: scale by tan(fov/2) ----------------
   logic              b_valid_ff;
   logic [2:0]        b_face_ff;
   logic              b_negx_ff, b_negy_ff;
   logic [1:0][PROD_W-1:0] b_prod_ff;
   logic [PROD_W-1:0] prodx_in, prody_in;

   assign prodx_in = a_magx_ff * half_fov_tangent_ff;
   assign prody_in = a_magy_ff * half_fov_tangent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_face_ff    <= a_face_ff;
         b_negx_ff    <= a_negx_ff;
         b_negy_ff    <= a_negy_ff;
         b_prod_ff[0] <= prodx_in;
         b_prod_ff[1] <= prody_in;
      end
   end

   // ---------------- divide by face size ----------------
   logic                   div_valid;
   logic [1:0][PROD_W-1:0] div_quo;
   logic [4:0]             div_tag;
   logic [1:0][DIM_W-1:0]  div_den;

   assign div_den[0] = fw;
   assign div_den[1] = fh;

   cte_div #(
      .NUM_W (PROD_W),
      .DEN_W (DIM_W),
      .TAG_W (5)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_num    (b_prod_ff),
      .in_den    (div_den),
      .in_tag    ({b_face_ff, b_negx_ff, b_negy_ff}),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // ---------------- stage C: face axes ----------------
   logic                    c_valid_ff;
   logic signed [VEC_W-1:0] c_nx_ff, c_ny_ff, c_nz_ff;
   logic signed [VEC_W-1:0] px_in, py_in, nx_in, ny_in, nz_in;
   localparam logic signed [VEC_W-1:0] AXIS_ONE = 32'sd65536;

   always_comb begin
      px_in = div_tag[1] ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
      py_in = div_tag[0] ? -$signed({1'b0, div_quo[1]}) : $signed({1'b0, div_quo[1]});
      unique case (div_tag[4:2])
         FACE_FRONT:  begin nx_in = px_in;     ny_in = py_in;     nz_in = AXIS_ONE;  end
         FACE_RIGHT:  begin nx_in = AXIS_ONE;  ny_in = py_in;     nz_in = -px_in;    end
         FACE_BACK:   begin nx_in = -px_in;    ny_in = py_in;     nz_in = -AXIS_ONE; end
         FACE_LEFT:   begin nx_in = -AXIS_ONE; ny_in = py_in;     nz_in = px_in;     end
         FACE_TOP:    begin nx_in = px_in;     ny_in = AXIS_ONE;  nz_in = -py_in;    end
         FACE_BOTTOM: begin nx_in = px_in;     ny_in = -AXIS_ONE; nz_in = py_in;     end
         default:     begin nx_in = '0;        ny_in = '0;        nz_in = '0;        end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_nx_ff <= nx_in;
         c_ny_ff <= ny_in;
         c_nz_ff <= nz_in;
      end
   end

   // ---------------- stage D: squares ----------------
   logic                    d_valid_ff;
   logic signed [VEC_W-1:0] d_nx_ff, d_ny_ff, d_nz_ff;
   logic [SQ_W-3:0]         d_sqx_ff, d_sqz_ff;
   logic [VEC_W-2:0]        absx, absz;
   logic [SQ_W-3:0]         sqx_in, sqz_in;

   always_comb begin
      absx   = c_nx_ff[VEC_W-1] ? (VEC_W-1)'(-c_nx_ff) : c_nx_ff[VEC_W-2:0];
      absz   = c_nz_ff[VEC_W-1] ? (VEC_W-1)'(-c_nz_ff) : c_nz_ff[VEC_W-2:0];
      sqx_in = absx * absx;
      sqz_in = absz * absz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_nx_ff  <= c_nx_ff;
         d_ny_ff  <= c_ny_ff;
         d_nz_ff  <= c_nz_ff;
         d_sqx_ff <= sqx_in;
         d_sqz_ff <= sqz_in;
      end
   end

   // ---------------- stage E: sum of squares ----------------
   logic                    e_valid_ff;
   logic signed [VEC_W-1:0] e_nx_ff, e_ny_ff, e_nz_ff;
   logic [SQ_W-1:0]         e_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_nx_ff  <= d_nx_ff;
         e_ny_ff  <= d_ny_ff;
         e_nz_ff  <= d_nz_ff;
         e_sum_ff <= SQ_W'(d_sqx_ff) + SQ_W'(d_sqz_ff);
      end
   end

   // ---------------- radius ----------------
   logic                   sq_valid;
   logic [RAD_W-1:0]       sq_root;
   logic [3*VEC_W-1:0]     sq_tag;

   cte_sqrt #(
      .ROOT_W (RAD_W),
      .TAG_W  (3 * VEC_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_val    (e_sum_ff),
      .in_tag    ({e_nx_ff, e_ny_ff, e_nz_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // ---------------- longitude and latitude ----------------
   logic signed [VEC_W:0]   cor_y [2];
   logic signed [VEC_W:0]   cor_x [2];
   logic                    cor_valid;
   logic signed [ANG_W-1:0] cor_ang [2];

   always_comb begin
      cor_y[0] = (VEC_W+1)'($signed(sq_tag[3*VEC_W-1:2*VEC_W]));
      cor_x[0] = (VEC_W+1)'($signed(sq_tag[VEC_W-1:0]));
      cor_y[1] = (VEC_W+1)'($signed(sq_tag[2*VEC_W-1:VEC_W]));
      cor_x[1] = $signed({1'b0, sq_root});
   end

   cte_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_y      (cor_y),
      .in_x      (cor_x),
      .out_valid (cor_valid),
      .out_ang   (cor_ang)
   );

   // ---------------- stage F: angles to fractions ----------------
   function automatic logic [32:0] clamp_turn(input logic signed [37:0] s);
      logic [32:0] r;
      if (s < 0) begin
         r = '0;
      end else if (s > 38'sd4294967296) begin
         r = 33'h1_0000_0000;
      end else begin
         r = s[32:0];
      end
      return r;
   endfunction

   logic               f_valid_ff;
   logic [U_W-1:0]     f_u_ff, f_v_ff;
   logic signed [37:0] su_in, sv_in;
   logic [32:0]        cu, cv;

   always_comb begin
      su_in = 38'(cor_ang[0]) + 38'(HALF_TURN);
      sv_in = (38'(cor_ang[1]) <<< 1) + 38'(HALF_TURN);
      cu    = clamp_turn(su_in);
      cv    = clamp_turn(sv_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= cor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_u_ff <= cu[32:32-FRAC_BITS];
         f_v_ff <= cv[32:32-FRAC_BITS];
      end
   end

   // ---------------- stage G: scale to source size ----------------
   logic           g_valid_ff;
   logic [U_W-1:0] g_u_ff, g_v_ff;
   logic [P_W-1:0] g_pu_ff, g_pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_u_ff  <= f_u_ff;
         g_v_ff  <= f_v_ff;
         g_pu_ff <= f_u_ff * sw;
         g_pv_ff <= f_v_ff * sh;
      end
   end

   // ---------------- stage H: wrap and clamp ----------------
   logic           h_valid_ff;
   rsp_beat_type   h_data_ff;
   rsp_beat_type   h_data_in;
   logic [SRC_W:0] tx, ty;

   always_comb begin
      tx = g_pu_ff[FRAC_BITS +: SRC_W+1];
      ty = g_pv_ff[FRAC_BITS +: SRC_W+1];
      h_data_in.src_x = (tx == {1'b0, sw}) ? '0 : 13'(tx);
      h_data_in.src_y = (ty > {1'b0, sh - 1'b1}) ? 13'(sh - 1'b1) : 13'(ty);
      h_data_in.longitude_frac = 17'(g_u_ff);
      h_data_in.latitude_frac  = 17'(g_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_data_ff <= h_data_in;
      end
   end

   // ---------------- output register and skid ----------------
   logic take;

   assign take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= h_valid_ff;
         end
      end else if (h_valid_ff && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : h_data_ff;
      end else if (!skid_valid_ff) begin
         skid_data_ff <= h_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output is empty");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      $past(skid_valid_ff) && $past(rsp_valid_ff) && $past(rsp_stall) |-> skid_valid_ff)
      else $error("parked beat dropped under stall");

   a_src_x_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff.src_x} < sw))
      else $error("src_x not below source width");

   a_src_y_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_data_ff.src_y} < sh))
      else $error("src_y not below source height");

   a_u_full_scale: assert property (@(posedge clock) disable iff (reset)
      g_valid_ff |-> (g_u_ff <= {1'b1, {FRAC_BITS{1'b0}}}))
      else $error("longitude fraction above full turn");

endmodule
`default_nettype wire
